// ----- rtl/pngx_pkg.sv -----
package pngx_pkg;

  // Result kinds carried in the low bits of the output data
  typedef enum logic [2:0] {
    KIND_TEXT   = 3'd0,
    KIND_EMPTY  = 3'd1,
    KIND_NOPNG  = 3'd2,
    KIND_NONE   = 3'd3,
    KIND_BADLEN = 3'd4
  } kind_e;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_SKIP = 6'b001000,
    PH_TEXT = 6'b010000,
    PH_DONE = 6'b100000
  } phase_e;

  // Chunk type "tEXt", first byte most significant
  localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;

  // Every chunk ends in a four-byte CRC
  localparam logic [31:0] CRC_BYTES = 32'd4;

  // Eight-byte file signature
  localparam logic [7:0] PNG_SIG [8] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  // One result from the parser
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] text_byte;
    logic       last;
  } pngx_res_t;

endpackage

// ----- rtl/pngx_parser.sv -----
module pngx_parser
  import pngx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        eos_i,
  input  logic [31:0] wanted_type_i,
  output pngx_res_t   res_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [30:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] rem_q, rem_d;
  logic        sig_ok_q, sig_ok_d;
  logic [31:0] rem_dec;
  pngx_res_t   res;

  // Remaining-count step shared by skip and text phases
  assign rem_dec = (rem_q != 32'd0) ? (rem_q - 32'd1) : rem_q;

  // Next state and result for the byte on the input
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    len_d    = len_q;
    type_d   = type_q;
    rem_d    = rem_q;
    sig_ok_d = sig_ok_q;
    res      = '{valid: 1'b0, kind: KIND_TEXT, text_byte: 8'd0, last: 1'b0};

    case (phase_q)
      PH_SIG: begin
        sig_ok_d = sig_ok_q & (data_byte_i == PNG_SIG[pos_q]);
        if (pos_q == 3'd7) begin
          pos_d = 3'd0;
          if (sig_ok_d) begin
            phase_d = PH_LEN;
          end else begin
            res.valid = 1'b1;
            res.kind  = KIND_NOPNG;
            phase_d   = PH_DONE;
          end
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
      PH_LEN: begin
        if (pos_q == 3'd0 && data_byte_i[7]) begin
          res.valid = 1'b1;
          res.kind  = KIND_BADLEN;
          phase_d   = PH_DONE;
        end else begin
          len_d = {len_q[22:0], data_byte_i};
          if (pos_q == 3'd3) begin
            pos_d   = 3'd0;
            type_d  = 32'd0;
            phase_d = PH_TYPE;
          end else begin
            pos_d = pos_q + 3'd1;
          end
        end
      end
      PH_TYPE: begin
        type_d = {type_q[23:0], data_byte_i};
        if (pos_q == 3'd3) begin
          pos_d = 3'd0;
          if (type_d == wanted_type_i) begin
            if (len_q == 31'd0) begin
              res.valid = 1'b1;
              res.kind  = KIND_EMPTY;
              phase_d   = PH_DONE;
            end else begin
              rem_d   = {1'b0, len_q};
              phase_d = PH_TEXT;
            end
          end else begin
            rem_d   = {1'b0, len_q} + CRC_BYTES;
            phase_d = PH_SKIP;
          end
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
      PH_SKIP: begin
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          len_d   = 31'd0;
          pos_d   = 3'd0;
          phase_d = PH_LEN;
        end
      end
      PH_TEXT: begin
        rem_d         = rem_dec;
        res.valid     = 1'b1;
        res.kind      = KIND_TEXT;
        res.text_byte = data_byte_i;
        res.last      = (rem_dec == 32'd0) | eos_i;
        if (rem_dec == 32'd0) begin
          phase_d = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    // End of file: report a truncated stream, then start over
    if (eos_i) begin
      if (!res.valid && phase_d != PH_DONE && phase_q != PH_DONE) begin
        res.valid = 1'b1;
        res.kind  = (phase_d == PH_SIG) ? KIND_NOPNG : KIND_NONE;
      end
      phase_d  = PH_SIG;
      pos_d    = 3'd0;
      len_d    = 31'd0;
      type_d   = 32'd0;
      rem_d    = 32'd0;
      sig_ok_d = 1'b1;
    end
  end

  assign res_o = '{valid:     res.valid & accept_i,
                   kind:      res.kind,
                   text_byte: res.text_byte,
                   last:      res.last};

  // Parser state, advanced on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIG;
      pos_q    <= 3'd0;
      len_q    <= 31'd0;
      type_q   <= 32'd0;
      rem_q    <= 32'd0;
      sig_ok_q <= 1'b1;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      type_q   <= type_d;
      rem_q    <= rem_d;
      sig_ok_q <= sig_ok_d;
    end
  end

  // An accepted end-of-file byte always leaves the parser at the signature start
  a_eos_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && eos_i |=> phase_q == PH_SIG && pos_q == 3'd0 && sig_ok_q)
    else $error("parser did not restart after end of file");

  // Once quiet, nothing more is reported until the next file
  a_done_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> !res_o.valid)
    else $error("result given while parser is quiet");

  // Payload phase always has bytes left to deliver
  a_text_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TEXT |-> rem_q != 32'd0)
    else $error("payload phase with nothing remaining");

  // Header byte counter stays within four bytes outside the signature
  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_SIG |-> pos_q <= 3'd3)
    else $error("header byte position out of range");

endmodule

// ----- rtl/png_text_chunk_extractor.sv -----
// PNG text chunk extractor.
// Input stream (s_axis): one file byte per request in tdata[7:0]; tlast marks
// the final byte of the file, after which the parser starts over on the next
// file. The block checks the signature, walks the chunks and sends out the
// payload bytes of the first chunk whose type matches the configuration
// register (reset value "tEXt"); all other chunks are skipped with their CRC.
// Output stream (m_axis): tdata[2:0] result kind, tdata[10:3] payload byte;
// tlast flags the final payload byte, or a payload byte cut short by the end
// of the file. Status kinds (empty chunk, not PNG, no chunk, bad length) come
// as single requests with zero data and tlast low.
// Throughput: one byte per cycle while m_axis is not stalled, set by the single state update per byte.
// Latency: a result appears on m_axis the cycle after its byte is accepted.
// The output register lets a new byte in while a result is still held; when
// the receiver stalls with a result held, s_axis_tready drops.
// Reset clears the parser to the signature start and the output to empty;
// the chunk type register returns to "tEXt". Write it only while idle.
module png_text_chunk_extractor
  import pngx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: wanted chunk type, first byte most significant
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // end_of_stream
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [2:0] result_kind, [10:3] text_byte, [15:11] zero
  output logic        m_axis_tlast   // last_text_byte
);

  logic [31:0] wanted_q;
  logic        out_valid_q;
  pngx_res_t   out_q;
  pngx_res_t   res;
  logic        accept;

  // Take a byte whenever the output slot is free or being emptied
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Wanted chunk type register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= TYPE_TEXT;
    end else if (cfg_we_i) begin
      wanted_q <= cfg_wdata_i;
    end
  end

  pngx_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (s_axis_tdata),
    .eos_i         (s_axis_tlast),
    .wanted_type_i (wanted_q),
    .res_o         (res)
  );

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= res.valid;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.text_byte, out_q.kind};
  assign m_axis_tlast  = out_q.last;

endmodule

// ----- tb/tb.sv -----
module tb;
  import pngx_pkg::*;

  localparam logic [63:0] FILE_MAGIC = 64'h8950_4E47_0D0A_1A0A;
  localparam int unsigned RUN_LIMIT  = 200_000;
  localparam int          PHASE_BYTES = 90;
  localparam int          DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } file_byte_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] text;
    logic       last;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0; // end_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [2:0] result_kind, [10:3] text_byte, [15:11] zero
  logic        m_axis_tlast;        // last_text_byte

  png_text_chunk_extractor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Parser copy kept by the bench
  logic [31:0] wanted_type = TYPE_TEXT;
  phase_e      walk_phase  = PH_SIG;
  logic [2:0]  byte_idx    = '0;
  logic [30:0] len_acc     = '0;
  logic [31:0] type_acc    = '0;
  logic [31:0] left_bytes  = '0;
  logic        sig_good    = 1'b1;

  file_byte_t  bytes_to_send[$];
  outcome_t    results_due[$];
  logic [7:0]  file_bytes[$];
  int          quiet_at = 1 << 30;
  int          gen_count = 0;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int unsigned cycles = 0;

  // No idling at all over a stretch of the run
  wire steady = (bytes_taken >= 300) && (bytes_taken < 480);

  function automatic logic [7:0] magic_byte(input int i);
    return FILE_MAGIC[63 - 8*i -: 8];
  endfunction

  // Add one byte to the end of the file being built
  task automatic append_byte(input logic [7:0] b);
    file_bytes = {file_bytes, b};
  endtask

  // Work out what one accepted byte produces, and advance the parser copy
  task automatic parse_byte(input logic [7:0] b, input logic eos);
    outcome_t res;
    bit       hit;
    phase_e   was;
    hit = 1'b0;
    was = walk_phase;
    res = '{KIND_TEXT, 8'h00, 1'b0};
    case (walk_phase)
      PH_SIG: begin
        if (b != magic_byte(byte_idx)) sig_good = 1'b0;
        if (byte_idx == 3'd7) begin
          byte_idx = '0;
          if (sig_good) begin
            walk_phase = PH_LEN;
          end else begin
            res.kind = KIND_NOPNG;
            hit = 1'b1;
            walk_phase = PH_DONE;
          end
        end else begin
          byte_idx++;
        end
      end
      PH_LEN: begin
        if (byte_idx == 3'd0 && b[7]) begin
          res.kind = KIND_BADLEN;
          hit = 1'b1;
          walk_phase = PH_DONE;
        end else begin
          len_acc = {len_acc[22:0], b};
          if (byte_idx == 3'd3) begin
            byte_idx = '0;
            type_acc = '0;
            walk_phase = PH_TYPE;
          end else begin
            byte_idx++;
          end
        end
      end
      PH_TYPE: begin
        type_acc = {type_acc[23:0], b};
        if (byte_idx == 3'd3) begin
          byte_idx = '0;
          if (type_acc == wanted_type) begin
            if (len_acc == '0) begin
              res.kind = KIND_EMPTY;
              hit = 1'b1;
              walk_phase = PH_DONE;
            end else begin
              left_bytes = {1'b0, len_acc};
              walk_phase = PH_TEXT;
            end
          end else begin
            left_bytes = {1'b0, len_acc} + CRC_BYTES;
            walk_phase = PH_SKIP;
          end
        end else begin
          byte_idx++;
        end
      end
      PH_SKIP: begin
        if (left_bytes != '0) left_bytes--;
        if (left_bytes == '0) begin
          len_acc = '0;
          byte_idx = '0;
          walk_phase = PH_LEN;
        end
      end
      PH_TEXT: begin
        if (left_bytes != '0) left_bytes--;
        res = '{KIND_TEXT, b, (left_bytes == '0) || eos};
        hit = 1'b1;
        if (left_bytes == '0) walk_phase = PH_DONE;
      end
      default: ;
    endcase

    // End of file: report an unfinished walk, then start over
    if (eos) begin
      if (!hit && walk_phase != PH_DONE && was != PH_DONE) begin
        res.kind = (walk_phase == PH_SIG) ? KIND_NOPNG : KIND_NONE;
        hit = 1'b1;
      end
      walk_phase = PH_SIG;
      byte_idx = '0;
      len_acc = '0;
      type_acc = '0;
      left_bytes = '0;
      sig_good = 1'b1;
    end
    if (hit) results_due = {results_due, res};
  endtask

  // Driver: one file byte per request
  always @(posedge clk_i or negedge rst_ni) begin
    file_byte_t fb;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken <= bytes_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bytes_to_send.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
          fb = bytes_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= fb.data;
          s_axis_tlast <= fb.eos;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest one due
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (m_axis_tdata[2:0] !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, m_axis_tdata[2:0]);
            mismatches++;
          end
          if (m_axis_tdata[10:3] !== want.text) begin
            $error("text_byte: expected %h, got %h", want.text, m_axis_tdata[10:3]);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_text_byte: expected %b, got %b", want.last, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tdata[15:11] !== 5'd0) begin
            $error("tdata padding: expected 0, got %h", m_axis_tdata[15:11]);
            mismatches++;
          end
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 30);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("png_text_chunk_extractor test failed");
      $finish;
    end
  end

  task automatic add_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) append_byte(w[8*i +: 8]);
  endtask

  task automatic add_magic();
    for (int i = 0; i < 8; i++) append_byte(magic_byte(i));
  endtask

  // Header, random payload and random CRC
  task automatic add_chunk(input logic [31:0] kind_code, input logic [31:0] len);
    add_word(len);
    add_word(kind_code);
    repeat (len) append_byte(8'($urandom));
    repeat (4) append_byte(8'($urandom));
  endtask

  // Queue the file, tlast on its final byte
  task automatic ship_file();
    file_byte_t fb;
    int         n;
    n = file_bytes.size();
    for (int i = 0; i < n; i++) begin
      fb.data = file_bytes[i];
      fb.eos = (i == n - 1);
      bytes_to_send = {bytes_to_send, fb};
    end
    gen_count += (quiet_at < n) ? quiet_at : n;
    file_bytes.delete();
    quiet_at = 1 << 30;
  endtask

  function automatic logic [31:0] other_type();
    logic [31:0] t;
    t = wanted_type;
    while (t == wanted_type) begin
      if ($urandom_range(99) < 30)
        t = wanted_type ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(3)));
      else
        t = $urandom();
    end
    return t;
  endfunction

  // Mostly well-formed files, some noise and broken signatures
  task automatic random_file();
    int          roll;
    int          sel;
    int          n;
    int          keep;
    logic [31:0] len;
    roll = $urandom_range(99);
    if (roll < 8) begin
      n = $urandom_range(1, 12);
      repeat (n) append_byte(8'($urandom));
    end else begin
      // corrupt one signature byte on broken files, none otherwise
      n = (roll < 16) ? $urandom_range(7) : 8;
      for (int i = 0; i < 8; i++)
        append_byte(magic_byte(i) ^ ((i == n) ? 8'(1 << $urandom_range(7)) : 8'h00));
      if (roll < 16) begin
        quiet_at = 8;
        repeat ($urandom_range(3)) append_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(3)) add_chunk(other_type(), $urandom_range(6));
        sel = $urandom_range(99);
        if (sel < 6) begin
          quiet_at = file_bytes.size() + 1;
          append_byte(8'h80 | 8'($urandom_range(127)));
          repeat ($urandom_range(2)) append_byte(8'($urandom));
        end else if (sel < 18) begin
          // long chunk, the file ends inside it
          len = ($urandom_range(3) == 0) ? 32'h7FFF_FFFF
                                         : ({1'b0, 31'($urandom)} | 32'h0100_0000);
          add_word(len);
          add_word((sel < 12) ? other_type() : wanted_type);
          repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
        end else if (sel < 80) begin
          len = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
          add_chunk(wanted_type, len);
          quiet_at = file_bytes.size() - 4;
          if ($urandom_range(1) == 1) add_chunk(other_type(), $urandom_range(3));
        end else begin
          add_chunk(other_type(), 0);
        end
      end
    end
    // cut the file short now and then
    if ($urandom_range(99) < 20) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
    ship_file();
  endtask

  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(posedge clk_i);
  endtask

  // Stimulus and register settings
  initial begin
    logic [31:0] type_plan [6];
    int          phase_base;
    type_plan = '{TYPE_TEXT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h4944_4154, TYPE_TEXT};
    type_plan[3] = $urandom();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // file ends inside the signature
    append_byte(8'h89);
    append_byte(8'h50);
    ship_file();
    // bad signature, then end while quiet
    repeat (8) append_byte(8'hFF);
    append_byte(8'h00);
    ship_file();
    // bad length on the final byte: one result only
    add_magic();
    append_byte(8'h80);
    ship_file();
    // empty matching chunk ending the file
    add_magic();
    add_word(32'd0);
    add_word(TYPE_TEXT);
    ship_file();
    // one payload byte arriving with the end of file
    add_magic();
    add_word(32'd1);
    add_word(TYPE_TEXT);
    append_byte(8'hFF);
    ship_file();

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk_i);
        cfg_wdata_i <= type_plan[p];
        cfg_we_i <= 1'b1;
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
        wanted_type = type_plan[p];
        @(negedge clk_i);
      end
      phase_base = gen_count;
      while (gen_count - phase_base < PHASE_BYTES) random_file();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0)
      $display("png_text_chunk_extractor test passed");
    else
      $display("png_text_chunk_extractor test failed");
    $finish;
  end

endmodule
